### rtl/data_frame_deframer_checker_assert.svh
// assertion macros shared by the deframer checker rtl
`ifndef DATA_FRAME_DEFRAMER_CHECKER_ASSERT_SVH
`define DATA_FRAME_DEFRAMER_CHECKER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define DFDC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define DFDC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/dfdc_pkg.sv
// package with types and constants of the deframer checker
package dfdc_pkg;

    localparam logic [7:0] FLAG_BYTE    = 8'h7E;
    localparam logic [7:0] ESC_BYTE     = 8'h7D;
    localparam logic [7:0] ESC_MASK     = 8'h20;
    localparam logic [6:0] ACK_LOW      = 7'h05;
    localparam logic [6:0] NACK_LOW     = 7'h01;
    localparam logic [7:0] ADDRESS_RESET = 8'h03;

    // apb map: one 32-bit register per word
    localparam int unsigned APB_AW = 3;
    localparam logic        REG_IDX_ADDRESS_BYTE = 1'b0;

    typedef enum logic [2:0] {
        PH_HUNT = 3'd0,
        PH_ADDR = 3'd1,
        PH_CTRL = 3'd2,
        PH_HCHK = 3'd3,
        PH_DATA = 3'd4
    } t_phase;

    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_ACCEPT  = 2'd1,
        KIND_REJECT  = 2'd2,
        KIND_REPEAT  = 2'd3
    } t_kind;

    // result control from the frame engine to the output stage
    typedef struct packed {
        logic  valid;
        t_kind kind;
    } t_res_ctl;

endpackage

### rtl/dfdc_apb_regs.sv
// apb configuration register holding the expected address byte
module dfdc_apb_regs
    import dfdc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output logic [7:0]        o_address_byte
);

    logic [7:0] r_address_byte;
    logic [7:0] n_address_byte;
    logic       sel_addr_reg;

    assign sel_addr_reg = (paddr[APB_AW-1:2] == REG_IDX_ADDRESS_BYTE);

    always_comb begin
        n_address_byte = r_address_byte;
        if (psel && penable && pwrite && sel_addr_reg) begin
            n_address_byte = pwdata[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_address_byte <= ADDRESS_RESET;
        end else begin
            r_address_byte <= n_address_byte;
        end
    end

    assign pready         = 1'b1;
    assign prdata         = sel_addr_reg ? {24'd0, r_address_byte} : 32'd0;
    assign o_address_byte = r_address_byte;

endmodule

### rtl/dfdc_frame_fsm.sv
// frame engine: header hunt, destuffing, xor check and result decode
module dfdc_frame_fsm
    import dfdc_pkg::*;
#(
    parameter int unsigned MAX_PAYLOAD = 1024,
    parameter int unsigned LW          = 11
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_step,
    input  logic [7:0]    i_byte,
    input  logic [7:0]    i_address_byte,
    output t_res_ctl      o_res,
    output logic [7:0]    o_payload_byte,
    output logic [LW-1:0] o_frame_length,
    output logic [7:0]    o_reply_control
);

    t_phase        r_phase,   n_phase;
    logic          r_seq,     n_seq;
    logic          r_esc,     n_esc;
    logic [7:0]    r_xor,     n_xor;
    logic [7:0]    r_held,    n_held;
    logic          r_have,    n_have;
    logic [LW-1:0] r_count,   n_count;

    logic          is_flag;
    logic          is_esc;
    logic [7:0]    data_b;
    logic [7:0]    ctl_b;
    logic [7:0]    other_b;
    logic          at_max;
    logic          frame_good;

    assign is_flag    = !r_esc && (i_byte == FLAG_BYTE);
    assign is_esc     = !r_esc && (i_byte == ESC_BYTE);
    assign data_b     = r_esc ? (i_byte ^ ESC_MASK) : i_byte;
    assign ctl_b      = {r_seq, 7'd0};
    assign other_b    = {~r_seq, 7'd0};
    assign at_max     = (r_count == LW'(MAX_PAYLOAD));
    assign frame_good = r_have && (r_xor == 8'd0);

    // next state
    always_comb begin
        n_phase = r_phase;
        n_seq   = r_seq;
        n_esc   = r_esc;
        n_xor   = r_xor;
        n_held  = r_held;
        n_have  = r_have;
        n_count = r_count;
        unique case (r_phase)
            PH_HUNT: begin
                if (i_byte == FLAG_BYTE) begin
                    n_phase = PH_ADDR;
                end
            end
            PH_ADDR: begin
                if (i_byte == FLAG_BYTE) begin
                    n_phase = PH_ADDR;
                end else if (i_byte == i_address_byte) begin
                    n_phase = PH_CTRL;
                end else begin
                    n_phase = PH_HUNT;
                end
            end
            PH_CTRL: begin
                if (i_byte == FLAG_BYTE) begin
                    n_phase = PH_ADDR;
                end else if (i_byte == ctl_b) begin
                    n_phase = PH_HCHK;
                end else begin
                    n_phase = PH_HUNT;
                end
            end
            PH_HCHK: begin
                if (i_byte == FLAG_BYTE) begin
                    n_phase = PH_ADDR;
                end else if (i_byte == (i_address_byte ^ ctl_b)) begin
                    n_phase = PH_DATA;
                    n_esc   = 1'b0;
                    n_xor   = 8'd0;
                    n_held  = 8'd0;
                    n_have  = 1'b0;
                    n_count = '0;
                end else begin
                    n_phase = PH_HUNT;
                end
            end
            PH_DATA: begin
                priority if (is_flag) begin
                    n_phase = PH_HUNT;
                    if (frame_good) begin
                        n_seq = ~r_seq;
                    end
                end else if (is_esc) begin
                    n_esc = 1'b1;
                end else begin
                    n_esc = 1'b0;
                    if (r_have && at_max) begin
                        n_phase = PH_HUNT;
                    end else begin
                        n_held = data_b;
                        n_have = 1'b1;
                        n_xor  = r_xor ^ data_b;
                        if (r_have) begin
                            n_count = r_count + LW'(1);
                        end
                    end
                end
            end
            default: begin
                n_phase = PH_HUNT;
            end
        endcase
    end

    // result decode
    always_comb begin
        o_res.valid     = 1'b0;
        o_res.kind      = KIND_PAYLOAD;
        o_payload_byte  = 8'd0;
        o_frame_length  = '0;
        o_reply_control = 8'd0;
        unique case (r_phase)
            PH_CTRL: begin
                if (i_byte != FLAG_BYTE && i_byte != ctl_b && i_byte == other_b) begin
                    o_res.valid     = 1'b1;
                    o_res.kind      = KIND_REPEAT;
                    o_reply_control = {r_seq, ACK_LOW};
                end
            end
            PH_DATA: begin
                priority if (is_flag) begin
                    o_res.valid = 1'b1;
                    if (frame_good) begin
                        o_res.kind      = KIND_ACCEPT;
                        o_frame_length  = r_count;
                        o_reply_control = {~r_seq, ACK_LOW};
                    end else begin
                        o_res.kind      = KIND_REJECT;
                        o_reply_control = {~r_seq, NACK_LOW};
                    end
                end else if (is_esc) begin
                    o_res.valid = 1'b0;
                end else if (r_have) begin
                    o_res.valid = 1'b1;
                    if (at_max) begin
                        o_res.kind      = KIND_REJECT;
                        o_reply_control = {~r_seq, NACK_LOW};
                    end else begin
                        o_res.kind     = KIND_PAYLOAD;
                        o_payload_byte = r_held;
                    end
                end else begin
                    o_res.valid = 1'b0;
                end
            end
            default: begin
                o_res.valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_seq   <= 1'b0;
            r_esc   <= 1'b0;
            r_xor   <= 8'd0;
            r_held  <= 8'd0;
            r_have  <= 1'b0;
            r_count <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_seq   <= n_seq;
            r_esc   <= n_esc;
            r_xor   <= n_xor;
            r_held  <= n_held;
            r_have  <= n_have;
            r_count <= n_count;
        end
    end

    `include "data_frame_deframer_checker_assert.svh"

    `DFDC_ASSERT_NOW(a_count_bounded, i_clk, i_rst_n, 1'b1, r_count <= LW'(MAX_PAYLOAD), "payload count beyond maximum")
    `DFDC_ASSERT_NEXT(a_accept_toggles_seq, i_clk, i_rst_n, i_step && o_res.valid && o_res.kind == KIND_ACCEPT, r_seq != $past(r_seq), "accepted frame did not toggle sequence bit")
    `DFDC_ASSERT_NEXT(a_seq_only_on_accept, i_clk, i_rst_n, !(i_step && o_res.valid && o_res.kind == KIND_ACCEPT), r_seq == $past(r_seq), "sequence bit changed without an accepted frame")
    `DFDC_ASSERT_NOW(a_frame_result_from_data, i_clk, i_rst_n, o_res.valid && (o_res.kind == KIND_ACCEPT || o_res.kind == KIND_PAYLOAD), r_phase == PH_DATA, "payload or accept outside the data phase")

endmodule

### rtl/dfdc_out_reg.sv
// output register of the result stream
module dfdc_out_reg
    import dfdc_pkg::*;
#(
    parameter int unsigned DW = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_load,
    input  t_kind         i_kind,
    input  logic [DW-1:0] i_data,
    output logic          o_free,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [DW-1:0] m_axis_tdata,
    output logic [1:0]    m_axis_tuser
);

    logic          r_valid, n_valid;
    logic [DW-1:0] r_data;
    t_kind         r_kind;

    always_comb begin
        priority if (i_load) begin
            n_valid = 1'b1;
        end else if (m_axis_tready) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= i_data;
            r_kind <= i_kind;
        end
    end

    assign o_free        = !r_valid || m_axis_tready;
    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = r_data;
    assign m_axis_tuser  = r_kind;

    `include "data_frame_deframer_checker_assert.svh"

    `DFDC_ASSERT_NOW(a_no_overwrite, i_clk, i_rst_n, i_load, !r_valid || m_axis_tready, "result register overwritten while stalled")
    `DFDC_ASSERT_NEXT(a_stall_keeps_beat, i_clk, i_rst_n, r_valid && !m_axis_tready, r_valid && r_data == $past(r_data), "stalled result beat lost")
    `DFDC_ASSERT_NEXT(a_load_shows_beat, i_clk, i_rst_n, i_load, r_valid, "loaded result not presented")

endmodule

### rtl/data_frame_deframer_checker.sv
// top level of the byte-stuffed frame receiver with xor block check
//
// usage
//  - s_axis carries raw line bytes, one per beat in tdata[7:0]
//  - m_axis carries results: tuser is the kind (payload byte, frame
//    accepted, frame rejected, repeated frame); tdata holds the destuffed
//    payload byte, the frame length and the ack/nack control byte to send
//  - the apb port holds one register, the expected address byte at 0x0
//  - a byte is registered on input and then decoded straight into the
//    output register
//  - one byte per cycle sustained while m_axis_tready is high; the header compare, destuffing and xor
//    update are a single pass of logic per byte
//  - payload bytes leave only once the next data byte arrives, so the last
//    byte before the closing flag is held back and taken as the trailer check
//  - reset puts the receiver into flag hunt with sequence bit zero, clears
//    both stream registers and loads address 0x03
//  - if the receiver stalls, the held result waits in the output register
//    and one more byte waits in the input register; s_axis_tready then
//    drops until the result beat is taken
//  - configuration must be written only while the stream is idle (a user rule)
module data_frame_deframer_checker
    import dfdc_pkg::*;
#(
    parameter int unsigned MAX_PAYLOAD = 1024
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // input stream
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [7:0]        s_axis_tdata,   // [7:0] rx_byte
    // result stream
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    // [7:0] payload_byte, [LW+7:8] frame_length, [LW+15:LW+8] reply_control,
    // zero fill above
    output logic [((16 + $clog2(MAX_PAYLOAD + 1) + 7) / 8) * 8 - 1:0] m_axis_tdata,
    output logic [1:0]        m_axis_tuser,   // [1:0] kind
    // configuration
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    // frame length field width follows the largest payload
    localparam int unsigned LW = $clog2(MAX_PAYLOAD + 1);
    localparam int unsigned DW = ((16 + LW + 7) / 8) * 8;

    // input register
    logic       r_in_valid, n_in_valid;
    logic [7:0] r_in_byte;

    // stage control
    logic       step;
    logic       out_free;
    logic       s_accept;

    logic [7:0]    address_byte;
    t_res_ctl      res;
    logic [7:0]    res_payload;
    logic [LW-1:0] res_length;
    logic [7:0]    res_reply;

    // the engine advances whenever a byte is waiting and the output
    // register can take whatever it may produce
    assign step          = r_in_valid && out_free;
    assign s_axis_tready = !r_in_valid || step;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    always_comb begin
        priority if (s_accept) begin
            n_in_valid = 1'b1;
        end else if (step) begin
            n_in_valid = 1'b0;
        end else begin
            n_in_valid = r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_in_byte <= s_axis_tdata;
        end
    end

    dfdc_apb_regs u_regs (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .o_address_byte (address_byte)
    );

    dfdc_frame_fsm #(
        .MAX_PAYLOAD (MAX_PAYLOAD),
        .LW          (LW)
    ) u_fsm (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_step          (step),
        .i_byte          (r_in_byte),
        .i_address_byte  (address_byte),
        .o_res           (res),
        .o_payload_byte  (res_payload),
        .o_frame_length  (res_length),
        .o_reply_control (res_reply)
    );

    dfdc_out_reg #(
        .DW (DW)
    ) u_out (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (step && res.valid),
        .i_kind        (res.kind),
        .i_data        (DW'({res_reply, res_length, res_payload})),
        .o_free        (out_free),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule
